### hdl/olist_pkg.sv
package olist_pkg;

	// store geometry
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int LEN_W    = 5;

	typedef enum logic [2:0] {
		OP_APPEND   = 3'd0,
		OP_PREPEND  = 3'd1,
		OP_REMOVE   = 3'd2,
		OP_CONTAINS = 3'd3,
		OP_DUMP     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// per-cell control, driven by the sequencer
	typedef struct packed {
		logic load_val;  // take the broadcast value
		logic shr;       // take the left neighbor's entry
		logic shl;       // close up behind a removed entry
		logic cmp_en;    // capture the match flag
		logic occupied;  // cell lies below occupancy
	} cell_ctl_t;

	// length field: occupancy masked to its five bits
	function automatic logic [LEN_W-1:0] len_of(input logic [CNT_W-1:0] occ);
		logic [CNT_W+LEN_W-1:0] tmp;
		tmp = {{LEN_W{1'b0}}, occ};
		return tmp[LEN_W-1:0];
	endfunction

endpackage

### hdl/olist_cell.sv
module olist_cell (
	input  logic                          clk,
	input  olist_pkg::cell_ctl_t          ctl,
	input  logic [olist_pkg::DATA_W-1:0]  value,
	input  logic [olist_pkg::DATA_W-1:0]  left_ent,
	input  logic [olist_pkg::DATA_W-1:0]  right_ent,
	input  logic                          prior_in,
	output logic [olist_pkg::DATA_W-1:0]  entry,
	output logic                          prior_out
);
	import olist_pkg::*;

	logic [DATA_W-1:0] entry_q;
	logic              match_q;
	logic              hit;

	// first-match chain: set from the first matching cell onward
	assign hit       = prior_in | match_q;
	assign prior_out = hit;
	assign entry     = entry_q;

	// entry and match flag, no reset
	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			match_q <= ctl.occupied && (entry_q == value);
		end
		priority if (ctl.load_val) begin
			entry_q <= value;
		end else if (ctl.shr) begin
			entry_q <= left_ent;
		end else if (ctl.shl && hit) begin
			entry_q <= right_ent;
		end
	end

endmodule

### hdl/ordered_list_engine_top.sv
// Append, prepend, dump of an empty list and unused opcodes give their item in the cycle
// after acceptance; remove and contains register the compare, then apply and give their item.
// Dump steps through the list and gives one element per cycle while the output is not stalled,
// set by the single read port on the cell chain. A new item is taken once the last result
// of the previous one is in the output register and out_stall is low.
// Reset clears occupancy, the sequencer and the output valid; entries are not reset.
module ordered_list_engine_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [2:0]                          opcode,
	input  logic signed [olist_pkg::DATA_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          status,
	output logic                                found,
	output logic signed [olist_pkg::DATA_W-1:0] element,
	output logic                                last,
	output logic [olist_pkg::LEN_W-1:0]         length
);
	import olist_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_APPLY = 3'b010,
		S_DUMP  = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  occ_q, occ_d;
	logic [IDX_W-1:0]  dcnt_q, dcnt_d;
	logic              is_remove_q, is_remove_d;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic              found_q;
	logic [DATA_W-1:0] element_q;
	logic              last_q;
	logic [LEN_W-1:0]  length_q;

	logic              out_free, accept, full, any_hit, dump_last;
	logic              emit;
	status_t           e_status;
	logic              e_found, e_last;
	logic [DATA_W-1:0] e_elem;
	logic              do_append, do_prepend, do_cmp, do_shl;

	cell_ctl_t         ctl   [CAPACITY];
	logic [DATA_W-1:0] ent   [CAPACITY];
	logic              prior [CAPACITY+1];

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == S_IDLE) && out_free);
	assign accept   = in_valid && !in_stall;
	assign full     = (occ_q == CNT_W'(CAPACITY));
	assign any_hit  = prior[CAPACITY];
	assign dump_last = ((CNT_W'(dcnt_q) + CNT_W'(1)) == occ_q);

	// sequencer
	always_comb begin
		state_d     = state_q;
		occ_d       = occ_q;
		dcnt_d      = dcnt_q;
		is_remove_d = is_remove_q;
		emit        = 1'b0;
		e_status    = ST_OK;
		e_found     = 1'b0;
		e_last      = 1'b1;
		e_elem      = '0;
		do_append   = 1'b0;
		do_prepend  = 1'b0;
		do_cmp      = 1'b0;
		do_shl      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (opcode)
						OP_APPEND, OP_PREPEND: begin
							emit = 1'b1;
							if (full) begin
								e_status = ST_FULL;
							end else begin
								do_append  = (opcode == OP_APPEND);
								do_prepend = (opcode == OP_PREPEND);
								occ_d      = occ_q + CNT_W'(1);
							end
						end
						OP_REMOVE, OP_CONTAINS: begin
							do_cmp      = 1'b1;
							is_remove_d = (opcode == OP_REMOVE);
							state_d     = S_APPLY;
						end
						OP_DUMP: begin
							if (occ_q == '0) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
							end else begin
								dcnt_d  = '0;
								state_d = S_DUMP;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_APPLY: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (any_hit) begin
						e_found = 1'b1;
						if (is_remove_q) begin
							do_shl = 1'b1;
							occ_d  = occ_q - CNT_W'(1);
						end
					end else begin
						e_status = ST_NOTFOUND;
					end
				end
			end
			S_DUMP: begin
				if (out_free) begin
					emit   = 1'b1;
					e_elem = ent[dcnt_q];
					e_last = dump_last;
					dcnt_d = dcnt_q + IDX_W'(1);
					if (dump_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// cell chain
	assign prior[0] = 1'b0;
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_ent, right_ent;
		if (i == 0) begin : g_head
			assign left_ent = value;
		end else begin : g_body
			assign left_ent = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_ent = ent[i];
		end else begin : g_inner
			assign right_ent = ent[i+1];
		end
		always_comb begin
			ctl[i].load_val = (do_append && (occ_q == CNT_W'(i))) || (do_prepend && (i == 0));
			ctl[i].shr      = do_prepend && (i != 0);
			ctl[i].shl      = do_shl;
			ctl[i].cmp_en   = do_cmp;
			ctl[i].occupied = (CNT_W'(i) < occ_q);
		end
		olist_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.value     (value),
			.left_ent  (left_ent),
			.right_ent (right_ent),
			.prior_in  (prior[i]),
			.entry     (ent[i]),
			.prior_out (prior[i+1])
		);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			dcnt_q      <= '0;
			is_remove_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			occ_q       <= occ_d;
			dcnt_q      <= dcnt_d;
			is_remove_q <= is_remove_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q  <= e_status;
			found_q   <= e_found;
			element_q <= e_elem;
			last_q    <= e_last;
			length_q  <= len_of(occ_d);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found     = found_q;
	assign element   = signed'(element_q);
	assign last      = last_q;
	assign length    = length_q;

	// checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(CAPACITY))
		else $error("occupancy above capacity");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_dump_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> (occ_q != '0))
		else $error("dump running on empty list");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (opcode == OP_APPEND) && !full) |=> (occ_q == $past(occ_q) + CNT_W'(1)))
		else $error("append did not grow the list");

endmodule

### tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import olist_pkg::*;

	// opcodes past dump are decoded as no-ops
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

	localparam int RESET_CYCLES = 7;
	localparam int MIX_ITEMS    = 18;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		status_t                   status;
		logic                      found;
		logic signed [DATA_W-1:0]  element;
		logic                      last;
		logic [LEN_W-1:0]          length;
	} list_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [2:0]                opcode;
	logic signed [DATA_W-1:0]  value;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [1:0]                status;
	logic                      found;
	logic signed [DATA_W-1:0]  element;
	logic                      last;
	logic [LEN_W-1:0]          length;

	// shadow copy of the list and the results still owed by the block
	logic signed [DATA_W-1:0]  shadow_list [CAPACITY];
	int                        shadow_count = 0;
	list_result_t              pending_results [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count    = 0;
	int cycle_count    = 0;

	ordered_list_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.found     (found),
		.element   (element),
		.last      (last),
		.length    (length)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver backpressure, changed on the falling edge
	always @(negedge clk) begin
		out_stall = ($urandom_range(0, 99) < recv_stall_pct);
	end

	// apply one operation to the shadow list and queue the results it owes
	function automatic void predict_list_op(input logic [2:0] op,
			input logic signed [DATA_W-1:0] v);
		list_result_t r;
		int hit;
		r.status  = ST_OK;
		r.found   = 1'b0;
		r.element = '0;
		r.last    = 1'b1;
		hit = -1;
		for (int i = 0; i < shadow_count; i++)
			if (hit < 0 && shadow_list[i] == v)
				hit = i;
		case (op)
			OP_APPEND: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					shadow_list[shadow_count] = v;
					shadow_count++;
				end
			end
			OP_PREPEND: begin
				if (shadow_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (int i = shadow_count; i > 0; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[0] = v;
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				if (hit < 0) begin
					r.status = ST_NOTFOUND;
				end else begin
					for (int i = hit; i + 1 < shadow_count; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_count--;
					r.found = 1'b1;
				end
			end
			OP_CONTAINS: begin
				if (hit < 0)
					r.status = ST_NOTFOUND;
				else
					r.found = 1'b1;
			end
			OP_DUMP: begin
				if (shadow_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// one result per element, head first
					r.length = LEN_W'(shadow_count);
					for (int i = 0; i < shadow_count; i++) begin
						r.element = shadow_list[i];
						r.last    = (i + 1 == shadow_count);
						pending_results.push_back(r);
					end
					return;
				end
			end
			default: ;
		endcase
		r.length = LEN_W'(shadow_count);
		pending_results.push_back(r);
	endfunction

	// drive one item on the falling edge, hold it until it is taken
	task automatic send_item(input logic [2:0] op, input logic signed [DATA_W-1:0] v);
		logic taken;
		taken = 1'b0;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		opcode   = op;
		value    = v;
		while (!taken) begin
			@(posedge clk);
			if (!in_stall)
				taken = 1'b1;
			else
				@(negedge clk);
		end
		predict_list_op(op, v);
	endtask

	function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_val,
			input logic [DATA_W-1:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t ns: %s mismatch: expected %h, got %h", $time, name, exp_val, got_val);
			error_count++;
		end
	endfunction

	// compare each result taken from the block with the oldest one owed
	always @(posedge clk) begin : check_results
		list_result_t r;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: unexpected item: expected none, got status %0d element %h",
					$time, status, element);
				error_count++;
			end else begin
				r = pending_results.pop_front();
				check_field("status", DATA_W'(r.status), DATA_W'(status));
				check_field("found", DATA_W'(r.found), DATA_W'(found));
				check_field("element", r.element, element);
				check_field("last", DATA_W'(r.last), DATA_W'(last));
				check_field("length", DATA_W'(r.length), DATA_W'(length));
			end
		end
	end

	// empty-list cases, value extremes, hits and misses, duplicates, no-op codes
	task automatic test_directed();
		send_item(OP_DUMP, '0);
		send_item(OP_REMOVE, 32'sd5);
		send_item(OP_CONTAINS, 32'sd5);
		send_item(OP_APPEND, 32'h7fff_ffff);
		send_item(OP_PREPEND, 32'h8000_0000);
		send_item(OP_APPEND, '0);
		send_item(OP_APPEND, '1);
		send_item(OP_APPEND, '1);
		send_item(OP_CONTAINS, '0);
		send_item(OP_CONTAINS, 32'sd1234);
		send_item(OP_REMOVE, '1);
		send_item(OP_DUMP, 32'h5a5a_5a5a);
		for (int k = OP_UNUSED_FIRST; k <= OP_UNUSED_LAST; k++)
			send_item(3'(k), $urandom);
		send_item(OP_DUMP, '0);
	endtask

	// fill to capacity, reject inserts, dump full, then empty it again
	task automatic test_capacity();
		while (shadow_count < CAPACITY)
			send_item($urandom_range(0, 1) ? OP_APPEND : OP_PREPEND, $urandom);
		send_item(OP_APPEND, $urandom);
		send_item(OP_PREPEND, $urandom);
		send_item(OP_DUMP, '0);
		while (shadow_count > 0) begin
			if ($urandom_range(0, 3) == 0)
				send_item(OP_CONTAINS, shadow_list[$urandom_range(0, shadow_count - 1)]);
			send_item(OP_REMOVE, shadow_list[$urandom_range(0, shadow_count - 1)]);
		end
		send_item(OP_DUMP, '0);
	endtask

	// random mix; values drawn from the list half the time so removes and searches hit
	task automatic test_random_mix(input int n_items);
		int roll;
		int pick;
		logic [2:0] op;
		logic signed [DATA_W-1:0] v;
		for (int n = 0; n < n_items; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 25)
				op = OP_APPEND;
			else if (roll < 45)
				op = OP_PREPEND;
			else if (roll < 65)
				op = OP_REMOVE;
			else if (roll < 82)
				op = OP_CONTAINS;
			else if (roll < 94)
				op = OP_DUMP;
			else
				op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
			// keep the list from sitting at capacity
			if (roll < 45 && shadow_count >= CAPACITY - 2 && $urandom_range(0, 1))
				op = OP_REMOVE;
			pick = $urandom_range(0, 9);
			if (pick < 5 && shadow_count > 0)
				v = shadow_list[$urandom_range(0, shadow_count - 1)];
			else if (pick < 7)
				v = DATA_W'(int'($urandom_range(0, 7)) - 4);
			else
				v = $urandom;
			send_item(op, v);
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		opcode   = '0;
		value    = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_capacity();

		// idle phases: none, sender gaps, receiver stalls, light on both
		test_random_mix(MIX_ITEMS);
		send_idle_pct  = 52;
		test_random_mix(MIX_ITEMS);
		send_idle_pct  = 0;
		recv_stall_pct = 52;
		test_random_mix(MIX_ITEMS);
		send_idle_pct  = 8;
		recv_stall_pct = 8;
		test_random_mix(MIX_ITEMS);

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
hdl/olist_pkg.sv
hdl/olist_cell.sv
hdl/ordered_list_engine_top.sv
tb/tb.sv
